### hdl/dats_pkg.sv
`timescale 1ns / 1ps
// Package for the alarm/beep tone sequencer: constants, types and the segment table.
package dats_pkg;

    localparam int SEGMENTS   = 6;
    localparam int PHASE_BITS = 16;
    localparam int SEG_BITS   = 3;
    localparam int ADDR_BITS  = 4;

    // Input commands; the unused code behaves as a tick
    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_START_ALARM = 2'd1;
    localparam logic [1:0] CMD_START_BEEP  = 2'd2;

    // Configuration register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_BEEP_LENGTH  = 2'd0;
    localparam logic [1:0] REG_BEEP_STEP    = 2'd1;
    localparam logic [1:0] REG_REPEAT_COUNT = 2'd2;

    localparam logic [15:0] BEEP_LENGTH_RST  = 16'd20000;
    localparam logic [15:0] BEEP_STEP_RST    = 16'd750;
    localparam logic [7:0]  REPEAT_COUNT_RST = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ALARM = 2'd1,
        MODE_BEEP  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [15:0] beep_length;
        logic [15:0] beep_step;
        logic [7:0]  repeat_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0] phase_index;
        logic [1:0] gain;
        logic       amp_on;
        logic       last_sample;
        logic       user_stopped;
    } sample_t;

    // Alarm segment lengths; rows past the fourth repeat the first row's length
    function automatic logic [15:0] seg_len(input logic [SEG_BITS-1:0] idx);
        logic [15:0] len;
        case (idx)
            3'd0:    len = 16'd65000;
            3'd1:    len = 16'd45000;
            3'd2:    len = 16'd35000;
            3'd3:    len = 16'd25000;
            default: len = 16'd65000;
        endcase
        return len;
    endfunction

    // Alarm segment phase steps
    function automatic logic [15:0] seg_step(input logic [SEG_BITS-1:0] idx);
        logic [15:0] step;
        case (idx)
            3'd0:    step = 16'd700;
            3'd1:    step = 16'd950;
            3'd2:    step = 16'd750;
            3'd3:    step = 16'd1150;
            default: step = 16'd0;
        endcase
        return step;
    endfunction

endpackage

### hdl/dds_alarm_tone_sequencer.sv
`timescale 1ns / 1ps
// Top level of the DDS alarm and beep tone sequencer.
//
// Tone sequencer around a 16-bit phase accumulator. Drive command 1 to arm
// the alarm or command 2 to arm a beep; those beats return no sample. Each
// tick beat (command 0, or the spare code 3) returns exactly one sample: the
// top byte of the accumulator as a sine-table index, two gain select bits,
// amp_on, and last_sample / user_stopped flags. The alarm walks six fixed
// segments and repeats the pass repeat_count times; its gain is the inverse
// of bits 6..5 of the pass number. Holding key_pressed during an alarm tick
// ends the alarm on that sample with user_stopped set. A beep plays
// beep_length samples at beep_step with gain ~(volume-1); volume 0 ignores
// the start. Idle ticks return an all-zero sample. Rate: one beat per clock
// in steady state; a tick beat's sample is formed from the accumulator and
// counter state and lands in the result register, which holds a stalled
// sample until the consumer takes it, so in_ready drops only when the
// result register is full and out_ready is low. Registers: beep_length at
// 0x0 (latched on start beep), beep_step at 0x4 and repeat_count at 0x8
// (both read live on every tick). Write configuration only while idle.
module dds_alarm_tone_sequencer
    import dats_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // command channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           command,
    input  logic [7:0]           volume,
    input  logic                 key_pressed,
    // sample channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           phase_index,
    output logic [1:0]           gain,
    output logic                 amp_on,
    output logic                 last_sample,
    output logic                 user_stopped
);

    cfg_t    cfg;
    sample_t sample;
    sample_t result;
    logic    sample_valid;
    logic    accept;

    // Advance the sequencer on every accepted beat
    assign accept = in_valid & in_ready;

    dats_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dats_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (accept),
        .command      (command),
        .volume       (volume),
        .key_pressed  (key_pressed),
        .cfg          (cfg),
        .sample       (sample),
        .sample_valid (sample_valid)
    );

    // Hold the sample until the consumer takes it
    dats_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (sample_valid),
        .sample     (sample),
        .take_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign phase_index  = result.phase_index;
    assign gain         = result.gain;
    assign amp_on       = result.amp_on;
    assign last_sample  = result.last_sample;
    assign user_stopped = result.user_stopped;

endmodule

### hdl/dats_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the tone sequencer.
module dats_cfg_regs
    import dats_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BEEP_LENGTH:  cfg_next.beep_length  = pwdata[15:0];
                REG_BEEP_STEP:    cfg_next.beep_step    = pwdata[15:0];
                REG_REPEAT_COUNT: cfg_next.repeat_count = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BEEP_LENGTH:  prdata = {16'd0, cfg_reg.beep_length};
            REG_BEEP_STEP:    prdata = {16'd0, cfg_reg.beep_step};
            REG_REPEAT_COUNT: prdata = {24'd0, cfg_reg.repeat_count};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beep_length  <= BEEP_LENGTH_RST;
            cfg_reg.beep_step    <= BEEP_STEP_RST;
            cfg_reg.repeat_count <= REPEAT_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/dats_core.sv
`timescale 1ns / 1ps
// Sequencer state, phase accumulator and per-beat sample formation.
module dats_core
    import dats_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [1:0] command,
    input  logic [7:0] volume,
    input  logic       key_pressed,
    input  cfg_t       cfg,
    output sample_t    sample,
    output logic       sample_valid
);

    logic [PHASE_BITS-1:0] phase_acc_reg,      phase_acc_next;
    mode_t                 mode_reg,           mode_next;
    logic [SEG_BITS-1:0]   segment_number_reg, segment_number_next;
    logic [15:0]           samples_left_reg,   samples_left_next;
    logic [7:0]            repeat_number_reg,  repeat_number_next;
    logic [1:0]            beep_gain_reg,      beep_gain_next;

    logic [PHASE_BITS-1:0] alarm_sum;
    logic [PHASE_BITS-1:0] beep_sum;
    logic [15:0]           left_dec;
    logic [SEG_BITS:0]     seg_inc;
    logic                  seg_wrap;
    logic [SEG_BITS-1:0]   seg_adv;
    logic [7:0]            repeat_adv;
    logic                  pass_done;
    logic [7:0]            vol_m1;
    logic                  is_tick;

    assign alarm_sum  = phase_acc_reg + PHASE_BITS'(seg_step(segment_number_reg));
    assign beep_sum   = phase_acc_reg + PHASE_BITS'(cfg.beep_step);
    assign left_dec   = samples_left_reg - 16'd1;
    assign seg_inc    = {1'b0, segment_number_reg} + (SEG_BITS+1)'(1);
    assign seg_wrap   = (seg_inc >= (SEG_BITS+1)'(SEGMENTS));
    assign seg_adv    = seg_wrap ? '0 : seg_inc[SEG_BITS-1:0];
    assign repeat_adv = seg_wrap ? repeat_number_reg + 8'd1 : repeat_number_reg;
    assign pass_done  = (repeat_adv >= cfg.repeat_count);
    assign vol_m1     = volume - 8'd1;
    assign is_tick    = (command != CMD_START_ALARM) && (command != CMD_START_BEEP);

    // Next state
    always_comb
    begin
        phase_acc_next      = phase_acc_reg;
        mode_next           = mode_reg;
        segment_number_next = segment_number_reg;
        samples_left_next   = samples_left_reg;
        repeat_number_next  = repeat_number_reg;
        beep_gain_next      = beep_gain_reg;
        if (step_en)
        begin
            case (command)
                CMD_START_ALARM:
                begin
                    phase_acc_next      = '0;
                    segment_number_next = '0;
                    repeat_number_next  = '0;
                    if (cfg.repeat_count == 8'd0)
                    begin
                        mode_next         = MODE_IDLE;
                        samples_left_next = '0;
                    end
                    else
                    begin
                        mode_next         = MODE_ALARM;
                        samples_left_next = seg_len('0);
                    end
                end
                CMD_START_BEEP:
                begin
                    if (volume != 8'd0)
                    begin
                        phase_acc_next    = '0;
                        beep_gain_next    = ~vol_m1[1:0];
                        samples_left_next = cfg.beep_length;
                        mode_next = (cfg.beep_length == 16'd0) ? MODE_IDLE : MODE_BEEP;
                    end
                end
                default:
                begin
                    case (mode_reg)
                        MODE_ALARM:
                        begin
                            phase_acc_next    = alarm_sum;
                            samples_left_next = left_dec;
                            if (key_pressed)
                            begin
                                mode_next         = MODE_IDLE;
                                samples_left_next = '0;
                            end
                            else if (left_dec == 16'd0)
                            begin
                                segment_number_next = seg_adv;
                                repeat_number_next  = repeat_adv;
                                if (pass_done)
                                    mode_next = MODE_IDLE;
                                else
                                    samples_left_next = seg_len(seg_adv);
                            end
                        end
                        MODE_BEEP:
                        begin
                            phase_acc_next    = beep_sum;
                            samples_left_next = left_dec;
                            if (left_dec == 16'd0)
                                mode_next = MODE_IDLE;
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    // Sample for the current tick
    always_comb
    begin
        sample       = '0;
        sample_valid = step_en & is_tick;
        case (mode_reg)
            MODE_ALARM:
            begin
                sample.phase_index  = alarm_sum[PHASE_BITS-1 -: 8];
                sample.gain         = ~repeat_number_reg[6:5];
                sample.amp_on       = 1'b1;
                sample.last_sample  = key_pressed | ((left_dec == 16'd0) & pass_done);
                sample.user_stopped = key_pressed;
            end
            MODE_BEEP:
            begin
                sample.phase_index = beep_sum[PHASE_BITS-1 -: 8];
                sample.gain        = beep_gain_reg;
                sample.amp_on      = 1'b1;
                sample.last_sample = (left_dec == 16'd0);
            end
            default:
            begin
                sample = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg      <= '0;
            mode_reg           <= MODE_IDLE;
            segment_number_reg <= '0;
            samples_left_reg   <= '0;
            repeat_number_reg  <= '0;
            beep_gain_reg      <= '0;
        end
        else
        begin
            phase_acc_reg      <= phase_acc_next;
            mode_reg           <= mode_next;
            segment_number_reg <= segment_number_next;
            samples_left_reg   <= samples_left_next;
            repeat_number_reg  <= repeat_number_next;
            beep_gain_reg      <= beep_gain_next;
        end
    end

endmodule

### hdl/dats_out_stage.sv
`timescale 1ns / 1ps
// Result register with valid/ready handshake toward the sample consumer.
module dats_out_stage
    import dats_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  sample_t sample,
    output logic    take_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t result
);

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;

    // Room for a new beat when empty or when the held beat leaves now
    assign take_ready = ~valid_reg | out_ready;
    assign valid_next = load | (valid_reg & ~out_ready);
    assign out_valid  = valid_reg;
    assign result     = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            sample_reg <= sample;
    end

endmodule

### hdl/dats_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tone sequencer and its bind to the top level.
module dats_checker
    import dats_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] phase_index,
    input logic [1:0] gain,
    input logic       amp_on,
    input logic       last_sample,
    input logic       user_stopped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase_index) && $stable(gain)
            && $stable(amp_on) && $stable(last_sample) && $stable(user_stopped))
        else $error("stalled sample changed or dropped");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !amp_on |-> phase_index == 8'd0 && gain == 2'd0
            && !last_sample && !user_stopped)
        else $error("idle sample not all zero");

    a_user_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && user_stopped |-> last_sample && amp_on)
        else $error("user stop without last played sample");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid
            && (command == CMD_START_ALARM || command == CMD_START_BEEP) |=> !out_valid)
        else $error("start beat produced a sample");

endmodule

bind dds_alarm_tone_sequencer dats_checker u_dats_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .phase_index  (phase_index),
    .gain         (gain),
    .amp_on       (amp_on),
    .last_sample  (last_sample),
    .user_stopped (user_stopped)
);
